### sv/ssfl_pkg.sv
// Package for the slab slot free-list allocator: request, response, queue entry
// and configuration types, register indexes, state codes and small helpers.
// No dependencies.
package ssfl_pkg;

	localparam int unsigned MAX_SLOTS_DEF = 2048;
	localparam int ADDR_W = 32;
	localparam int SIZE_W = 16;
	localparam int CNT_W = 12;
	localparam int LIM_W = 17;
	localparam int CFG_IDX_W = 2;

	localparam logic [CFG_IDX_W-1:0] CFG_REGION_BASE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SLOT_SIZE = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SLOT_COUNT = 2'd2;

	localparam logic REQ_ALLOC = 1'b0;
	localparam logic REQ_FREE = 1'b1;

	localparam logic [ADDR_W-1:0] BASE_RST = 32'd0;
	localparam logic [SIZE_W-1:0] SIZE_RST = 16'd64;
	localparam logic [CNT_W-1:0] COUNT_RST = 12'd1;

	typedef enum logic [1:0] {
		OP_ALLOC,
		OP_FREE,
		OP_REFUSE
	} op_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_MUL,
		BK_ADD,
		BK_DIV,
		BK_PUSH,
		BK_DONE
	} back_state_t;

	typedef struct packed {
		logic              req_type;
		logic [ADDR_W-1:0] free_address;
	} req_t;

	typedef struct packed {
		logic              granted;
		logic [ADDR_W-1:0] slot_address;
		logic [CNT_W-1:0]  in_use;
	} rsp_t;

	typedef struct packed {
		logic [ADDR_W-1:0] region_base;
		logic [SIZE_W-1:0] slot_size;
		logic [CNT_W-1:0]  slot_count;
	} cfg_t;

	typedef struct packed {
		op_t               op;
		logic [ADDR_W-1:0] diff;
	} cmd_t;

	function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] size);
		return (size == '0) ? SIZE_W'(1) : size;
	endfunction

	function automatic logic [CNT_W-1:0] eff_count(input logic [CNT_W-1:0] cnt,
			input logic [LIM_W-1:0] lim);
		logic [LIM_W-1:0] c;
		c = LIM_W'(cnt);
		return (c < lim) ? cnt : lim[CNT_W-1:0];
	endfunction

endpackage

### sv/ssfl_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ssfl_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic                                   re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

### sv/ssfl_queue.sv
// Two-entry command queue between the classifying front and the executing back.
// Depends on ssfl_pkg.
module ssfl_queue
	import ssfl_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push_valid,
	output logic push_ready,
	input  cmd_t push_cmd,
	output logic pop_valid,
	input  logic pop,
	output cmd_t pop_cmd
);

	cmd_t       mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] fill_q;
	logic       do_push;

	assign push_ready = (fill_q != 2'd2);
	assign pop_valid = (fill_q != 2'd0);
	assign pop_cmd = mem_q[rd_ptr_q];
	assign do_push = push_valid && push_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (do_push && !pop) begin
				fill_q <= fill_q + 2'd1;
			end else if (pop && !do_push) begin
				fill_q <= fill_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

endmodule

### sv/ssfl_div.sv
// Bit-serial restoring divider: offset by slot size, one quotient bit a cycle.
// The quotient is known to fit CNT_W bits. Depends on ssfl_pkg.
module ssfl_div
	import ssfl_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [ADDR_W-1:0] dividend,
	input  logic [SIZE_W-1:0] divisor,
	output logic              done,
	output logic [CNT_W-1:0]  quotient
);

	localparam int STEP_W = $clog2(CNT_W);

	logic [ADDR_W-1:0] rem_q;
	logic [ADDR_W-1:0] dsr_q;
	logic [CNT_W-1:0]  quo_q;
	logic [STEP_W-1:0] step_q;
	logic              busy_q;
	logic              done_q;
	logic              fits;

	assign fits = (rem_q >= dsr_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= STEP_W'(CNT_W - 1);
			end else if (busy_q) begin
				step_q <= step_q - STEP_W'(1);
				if (step_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= dividend;
			dsr_q <= ADDR_W'(divisor) << (CNT_W - 1);
			quo_q <= '0;
		end else if (busy_q) begin
			if (fits) begin
				rem_q <= rem_q - dsr_q;
			end
			quo_q <= {quo_q[CNT_W-2:0], fits};
			dsr_q <= dsr_q >> 1;
		end
	end

	assign done = done_q;
	assign quotient = quo_q;

endmodule

### sv/ssfl_front.sv
// Front end: takes requests, range-checks frees against the slot region and
// queues classified commands. Two register stages. Depends on ssfl_pkg.
module ssfl_front
	import ssfl_pkg::*;
#(
	parameter int unsigned MAX_SLOTS = MAX_SLOTS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  cfg_t cfg,
	input  logic req_valid,
	output logic req_stall,
	input  req_t req,
	output logic cmd_valid,
	input  logic cmd_ready,
	output cmd_t cmd
);

	logic              s1_v_q;
	logic              s2_v_q;
	req_t              req_s1;
	req_t              req_s2;
	logic [27:0]       prod_s2;
	logic              nz_s2;
	logic              s2_free;
	logic              s1_adv;
	logic              accept;
	logic [CNT_W-1:0]  n;
	logic [CNT_W-1:0]  nm1;
	logic [SIZE_W-1:0] esize;
	logic [ADDR_W:0]   last;
	logic              in_range;

	assign n = eff_count(cfg.slot_count, LIM_W'(MAX_SLOTS));
	assign nm1 = n - CNT_W'(1);
	assign esize = eff_size(cfg.slot_size);

	assign s2_free = !s2_v_q || cmd_ready;
	assign s1_adv = s1_v_q && s2_free;
	assign req_stall = s1_v_q && !s2_free;
	assign accept = req_valid && !req_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v_q <= 1'b0;
			s2_v_q <= 1'b0;
		end else begin
			if (accept) begin
				s1_v_q <= 1'b1;
			end else if (s1_adv) begin
				s1_v_q <= 1'b0;
			end
			if (s1_adv) begin
				s2_v_q <= 1'b1;
			end else if (cmd_ready) begin
				s2_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_s1 <= req;
		end
		if (s1_adv) begin
			req_s2 <= req_s1;
			prod_s2 <= 28'(nm1) * 28'(esize);
			nz_s2 <= (n != '0);
		end
	end

	assign last = (ADDR_W + 1)'(cfg.region_base) + (ADDR_W + 1)'(prod_s2);
	assign in_range = nz_s2 && (req_s2.free_address >= cfg.region_base)
		&& ((ADDR_W + 1)'(req_s2.free_address) <= last);

	always_comb begin
		cmd.diff = req_s2.free_address - cfg.region_base;
		priority if (req_s2.req_type == REQ_ALLOC) begin
			cmd.op = OP_ALLOC;
		end else if (in_range) begin
			cmd.op = OP_FREE;
		end else begin
			cmd.op = OP_REFUSE;
		end
	end

	assign cmd_valid = s2_v_q;

endmodule

### sv/ssfl_back.sv
// Back end: pops commands, serves allocations from the free list or the fresh
// counter, divides and pushes frees, holds the response register.
// Depends on ssfl_pkg, ssfl_ram, ssfl_div.
module ssfl_back
	import ssfl_pkg::*;
#(
	parameter int unsigned MAX_SLOTS = MAX_SLOTS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  cfg_t cfg,
	input  logic cmd_valid,
	output logic cmd_pop,
	input  cmd_t cmd,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp
);

	localparam int IW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;

	back_state_t       state_q;
	back_state_t       state_d;
	logic [IW-1:0]     head_q;
	logic              head_v_q;
	logic [CNT_W-1:0]  fresh_q;
	logic [CNT_W-1:0]  used_q;
	logic [IW-1:0]     idx_q;
	logic              from_list_q;
	logic [ADDR_W-1:0] prod_q;
	rsp_t              res_q;
	rsp_t              out_q;
	logic              out_v_q;

	logic [CNT_W-1:0]  n;
	logic [SIZE_W-1:0] esize;
	logic              fresh_ok;
	logic              out_free;
	logic [LIM_W-1:0]  fresh_ext;
	logic [LIM_W-1:0]  quo_ext;
	logic [IW-1:0]     fresh_idx;
	logic [IW-1:0]     quo_idx;
	logic [CNT_W-1:0]  used_inc;
	logic [CNT_W-1:0]  used_dec;

	logic              ram_we;
	logic              ram_re;
	logic [IW:0]       ram_rdata;
	logic              div_start;
	logic              div_done;
	logic [CNT_W-1:0]  quotient;

	assign n = eff_count(cfg.slot_count, LIM_W'(MAX_SLOTS));
	assign esize = eff_size(cfg.slot_size);
	assign fresh_ok = (fresh_q < n);
	assign out_free = !out_v_q || !rsp_stall;
	assign fresh_ext = LIM_W'(fresh_q);
	assign quo_ext = LIM_W'(quotient);
	assign fresh_idx = fresh_ext[IW-1:0];
	assign quo_idx = quo_ext[IW-1:0];
	assign used_inc = (used_q != '1) ? used_q + CNT_W'(1) : used_q;
	assign used_dec = (used_q != '0) ? used_q - CNT_W'(1) : used_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			BK_IDLE: begin
				if (cmd_valid) begin
					unique case (cmd.op)
						OP_ALLOC: state_d = (head_v_q || fresh_ok) ? BK_MUL : BK_DONE;
						OP_FREE: state_d = BK_DIV;
						default: state_d = BK_DONE;
					endcase
				end
			end
			BK_MUL: state_d = BK_ADD;
			BK_ADD: state_d = BK_DONE;
			BK_DIV: begin
				if (div_done) begin
					state_d = BK_PUSH;
				end
			end
			BK_PUSH: state_d = BK_DONE;
			BK_DONE: begin
				if (out_free) begin
					state_d = BK_IDLE;
				end
			end
			default: state_d = BK_IDLE;
		endcase
	end

	always_comb begin
		cmd_pop = (state_q == BK_IDLE) && cmd_valid;
		ram_re = cmd_pop && (cmd.op == OP_ALLOC) && head_v_q;
		div_start = cmd_pop && (cmd.op == OP_FREE);
		ram_we = (state_q == BK_PUSH);
	end

	ssfl_ram #(
		.WIDTH(IW + 1),
		.DEPTH(MAX_SLOTS)
	) u_link (
		.clk  (clk),
		.we   (ram_we),
		.waddr(quo_idx),
		.wdata({head_v_q, head_q}),
		.re   (ram_re),
		.raddr(head_q),
		.rdata(ram_rdata)
	);

	ssfl_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.dividend(cmd.diff),
		.divisor (esize),
		.done    (div_done),
		.quotient(quotient)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
			head_q <= '0;
			head_v_q <= 1'b0;
			fresh_q <= '0;
			used_q <= '0;
			out_v_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd_pop && (cmd.op == OP_ALLOC) && !head_v_q && fresh_ok) begin
				fresh_q <= fresh_q + CNT_W'(1);
			end
			if ((state_q == BK_MUL) && from_list_q) begin
				head_q <= ram_rdata[IW-1:0];
				head_v_q <= ram_rdata[IW];
			end
			if (state_q == BK_ADD) begin
				used_q <= used_inc;
			end
			if (state_q == BK_PUSH) begin
				head_q <= quo_idx;
				head_v_q <= 1'b1;
				used_q <= used_dec;
			end
			if ((state_q == BK_DONE) && out_free) begin
				out_v_q <= 1'b1;
			end else if (out_v_q && !rsp_stall) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			idx_q <= head_v_q ? head_q : fresh_idx;
			from_list_q <= head_v_q;
			res_q.granted <= 1'b0;
			res_q.slot_address <= '0;
			res_q.in_use <= used_q;
		end
		if (state_q == BK_MUL) begin
			prod_q <= ADDR_W'(idx_q) * ADDR_W'(esize);
		end
		if (state_q == BK_ADD) begin
			res_q.granted <= 1'b1;
			res_q.slot_address <= cfg.region_base + prod_q;
			res_q.in_use <= used_inc;
		end
		if (state_q == BK_PUSH) begin
			res_q.granted <= 1'b1;
			res_q.slot_address <= '0;
			res_q.in_use <= used_dec;
		end
		if ((state_q == BK_DONE) && out_free) begin
			out_q <= res_q;
		end
	end

	assign rsp_valid = out_v_q;
	assign rsp = out_q;

endmodule

### sv/slab_slot_free_list_allocator.sv
// The back end serves one command at a time: it pops the next only after the last
// response has gone to the output register. For a free, the bit-serial divider makes one
// quotient bit a cycle. The front and a two-entry queue keep taking requests while a
// response waits, until they are full.
// Reset clears control state and loads region_base 0, slot_size 64, slot_count 1;
// the link memory is not cleared, as it is only read after being written.
module slab_slot_free_list_allocator
	import ssfl_pkg::*;
#(
	parameter int unsigned MAX_SLOTS = MAX_SLOTS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [ADDR_W-1:0]    cfg_data,
	input  logic                 req_valid,
	output logic                 req_stall,
	input  req_t                 req,
	output logic                 rsp_valid,
	input  logic                 rsp_stall,
	output rsp_t                 rsp
);

	cfg_t cfg_q;
	logic q_push_valid;
	logic q_push_ready;
	cmd_t q_push_cmd;
	logic q_pop_valid;
	logic q_pop;
	cmd_t q_pop_cmd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.region_base <= BASE_RST;
			cfg_q.slot_size <= SIZE_RST;
			cfg_q.slot_count <= COUNT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_REGION_BASE: cfg_q.region_base <= cfg_data;
				CFG_SLOT_SIZE: cfg_q.slot_size <= cfg_data[SIZE_W-1:0];
				CFG_SLOT_COUNT: cfg_q.slot_count <= cfg_data[CNT_W-1:0];
				default: cfg_q <= cfg_q;
			endcase
		end
	end

	ssfl_front #(
		.MAX_SLOTS(MAX_SLOTS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req      (req),
		.cmd_valid(q_push_valid),
		.cmd_ready(q_push_ready),
		.cmd      (q_push_cmd)
	);

	ssfl_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_valid(q_push_valid),
		.push_ready(q_push_ready),
		.push_cmd  (q_push_cmd),
		.pop_valid (q_pop_valid),
		.pop       (q_pop),
		.pop_cmd   (q_pop_cmd)
	);

	ssfl_back #(
		.MAX_SLOTS(MAX_SLOTS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.cmd_valid(q_pop_valid),
		.cmd_pop  (q_pop),
		.cmd      (q_pop_cmd),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp      (rsp)
	);

endmodule

### sv/ssfl_checker.sv
// Port-level checker for the slab slot allocator, bound to the top level.
// Depends on ssfl_pkg and slab_slot_free_list_allocator.
module ssfl_checker
	import ssfl_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	input logic req_stall,
	input req_t req,
	input logic rsp_valid,
	input logic rsp_stall,
	input rsp_t rsp
);

	a_req_hold: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_stall |=> req_valid && $stable(req))
		else $error("stalled request changed or dropped");

	a_refused_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp.granted |-> rsp.slot_address == '0)
		else $error("refused request carries a slot address");

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("stalled response changed or dropped");

	a_alloc_in_use: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.granted && rsp.slot_address != '0 |-> rsp.in_use != '0)
		else $error("granted allocation leaves no slot in use");

endmodule

bind slab_slot_free_list_allocator ssfl_checker u_ssfl_checker (.*);

### bench/slab_slot_checker.sv
`timescale 1ns / 1ps
// Response checker for the slab slot free-list allocator: mirrors the register
// writes, predicts one response per accepted request and compares in order.
// Depends on ssfl_pkg for the payload types, register indexes and reset values.
module slab_slot_checker
	import ssfl_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [ADDR_W-1:0]    cfg_data,
	input  logic                 req_valid,
	input  logic                 req_stall,
	input  req_t                 req,
	input  logic                 rsp_valid,
	input  logic                 rsp_stall,
	input  rsp_t                 rsp,
	output int unsigned          errors,
	output int unsigned          outstanding
);

	logic [ADDR_W-1:0] base_r;
	logic [SIZE_W-1:0] size_r;
	logic [CNT_W-1:0]  count_r;

	logic [CNT_W-1:0] slot_link [MAX_SLOTS_DEF];
	bit               link_live [MAX_SLOTS_DEF];
	int unsigned      list_top;
	bit               list_live;
	int unsigned      fresh_next;
	logic [CNT_W-1:0] used_n;

	rsp_t        slot_q [$];
	int unsigned bad_n;

	task automatic serve_request(input req_t r);
		int unsigned     n;
		int unsigned     idx;
		longint unsigned sz;
		longint unsigned addr;
		longint unsigned hi_addr;
		rsp_t            want;
		n = (count_r > MAX_SLOTS_DEF) ? MAX_SLOTS_DEF : count_r;
		sz = (size_r == '0) ? 1 : size_r;
		want = '0;
		if (r.req_type == REQ_ALLOC) begin
			if (list_live) begin
				idx = list_top;
				list_top = slot_link[idx];
				list_live = link_live[idx];
				want.granted = 1'b1;
			end else if (fresh_next < n) begin
				idx = fresh_next;
				fresh_next++;
				want.granted = 1'b1;
			end
			if (want.granted) begin
				addr = base_r + idx * sz;
				want.slot_address = addr[ADDR_W-1:0];
				if (used_n != '1)
					used_n++;
			end
		end else if (n != 0) begin
			addr = r.free_address;
			hi_addr = base_r + (n - 1) * sz;
			if (addr >= base_r && addr <= hi_addr) begin
				idx = 32'((addr - base_r) / sz);
				slot_link[idx] = list_top[CNT_W-1:0];
				link_live[idx] = list_live;
				list_top = idx;
				list_live = 1'b1;
				if (used_n != '0)
					used_n--;
				want.granted = 1'b1;
			end
		end
		want.in_use = used_n;
		slot_q.push_back(want);
	endtask

	task automatic report(input string what, input rsp_t want);
		bad_n++;
		if (bad_n <= 10)
			$display("%0t %s: granted %0b/%0b slot_address %h/%h in_use %0d/%0d (expected/actual)",
				$time, what, want.granted, rsp.granted, want.slot_address, rsp.slot_address,
				want.in_use, rsp.in_use);
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		rsp_t want;
		if (!arst_n) begin
			base_r = BASE_RST;
			size_r = SIZE_RST;
			count_r = COUNT_RST;
			list_top = 0;
			list_live = 1'b0;
			fresh_next = 0;
			used_n = '0;
			slot_q.delete();
			bad_n = 0;
			errors <= 0;
			outstanding <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_REGION_BASE: base_r = cfg_data;
					CFG_SLOT_SIZE: size_r = cfg_data[SIZE_W-1:0];
					CFG_SLOT_COUNT: count_r = cfg_data[CNT_W-1:0];
					default: ;
				endcase
			end
			if (req_valid && !req_stall)
				serve_request(req);
			if (rsp_valid && !rsp_stall) begin
				if (slot_q.size() == 0) begin
					report("response with none pending", '0);
				end else begin
					want = slot_q.pop_front();
					if (rsp.granted !== want.granted || rsp.slot_address !== want.slot_address
							|| rsp.in_use !== want.in_use)
						report("bad response", want);
				end
			end
			errors <= bad_n;
			outstanding <= slot_q.size();
		end
	end

endmodule

### bench/tb_slab_slot_free_list_allocator.sv
`timescale 1ns / 1ps
// Top of the slab slot free-list allocator bench: clock, reset, register writes,
// directed and random allocate/free requests, and the verdict.
// Depends on ssfl_pkg, the allocator and slab_slot_checker.
module tb_slab_slot_free_list_allocator;
	import ssfl_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 1000000;
	localparam int unsigned PHASES = 12;
	localparam int unsigned PHASE_ITEMS = 170;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [ADDR_W-1:0]    cfg_data;
	logic                 req_valid;
	logic                 req_stall;
	req_t                 req;
	logic                 rsp_valid;
	logic                 rsp_stall;
	rsp_t                 rsp;
	int unsigned          errors;
	int unsigned          outstanding;

	int unsigned       gap_pct;
	int unsigned       stall_pct;
	int unsigned       cycles;
	logic [ADDR_W-1:0] t_base;
	logic [SIZE_W-1:0] t_size;
	logic [CNT_W-1:0]  t_count;

	slab_slot_free_list_allocator DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	slab_slot_checker checker_i (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.req_valid   (req_valid),
		.req_stall   (req_stall),
		.req         (req),
		.rsp_valid   (rsp_valid),
		.rsp_stall   (rsp_stall),
		.rsp         (rsp),
		.errors      (errors),
		.outstanding (outstanding)
	);

	always #1 clk = ~clk;

	always @(posedge clk) begin
		rsp_stall <= ($urandom_range(99) < stall_pct);
		cycles++;
		if (cycles == CYCLE_LIMIT) begin
			$display("slab_slot_free_list_allocator: mismatch");
			$finish;
		end
	end

	function automatic req_t mk_req(input logic kind, input logic [ADDR_W-1:0] addr);
		req_t r;
		r.req_type = kind;
		r.free_address = addr;
		return r;
	endfunction

	function automatic req_t random_request();
		req_t            r;
		int unsigned     pick;
		int unsigned     n;
		longint unsigned sz;
		longint unsigned a;
		pick = $urandom_range(99);
		n = (t_count > MAX_SLOTS_DEF) ? MAX_SLOTS_DEF : t_count;
		sz = (t_size == '0) ? 1 : t_size;
		r = mk_req(REQ_ALLOC, $urandom);
		if (pick >= 50) begin
			r.req_type = REQ_FREE;
			if (pick < 85 && n != 0) begin
				a = t_base + longint'($urandom_range(n - 1)) * sz;
				if ($urandom_range(3) == 0)
					a += $urandom_range(32'(sz - 1));
				r.free_address = a[ADDR_W-1:0];
			end else if (pick < 90) begin
				r.free_address = t_base - 1;
			end else if (pick < 95) begin
				a = t_base + (n == 0 ? 0 : (n - 1)) * sz + 1;
				r.free_address = a[ADDR_W-1:0];
			end
		end
		return r;
	endfunction

	task automatic send(input req_t r);
		while ($urandom_range(99) < gap_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req <= r;
		do @(posedge clk); while (req_stall);
	endtask

	task automatic drain();
		req_valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
	endtask

	task automatic load_config(input logic [ADDR_W-1:0] base, input logic [SIZE_W-1:0] size,
			input logic [CNT_W-1:0] count);
		t_base = base;
		t_size = size;
		t_count = count;
		cfg_we <= 1'b1;
		cfg_index <= CFG_REGION_BASE;
		cfg_data <= base;
		@(posedge clk);
		cfg_index <= CFG_SLOT_SIZE;
		cfg_data <= ADDR_W'(size);
		@(posedge clk);
		cfg_index <= CFG_SLOT_COUNT;
		cfg_data <= ADDR_W'(count);
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin
		logic [ADDR_W-1:0] nb;
		logic [SIZE_W-1:0] ns;
		logic [CNT_W-1:0]  nc;
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_REGION_BASE;
		cfg_data = '0;
		req_valid = 1'b0;
		req = '0;
		rsp_stall = 1'b0;
		cycles = 0;
		gap_pct = 23;
		stall_pct = 77;
		t_base = BASE_RST;
		t_size = SIZE_RST;
		t_count = COUNT_RST;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// one slot after reset: full region, unaligned and double free, out of range
		send(mk_req(REQ_ALLOC, 32'hFFFF_FFFF));
		send(mk_req(REQ_ALLOC, 32'h0000_0000));
		send(mk_req(REQ_FREE, 32'h0000_0000));
		send(mk_req(REQ_FREE, 32'h0000_003F));
		send(mk_req(REQ_ALLOC, 32'h0000_0000));
		send(mk_req(REQ_ALLOC, 32'h0000_0000));
		send(mk_req(REQ_ALLOC, 32'h0000_0000));
		send(mk_req(REQ_FREE, 32'h0000_0040));
		send(mk_req(REQ_FREE, 32'hFFFF_FFFF));

		// zero count with zero size
		drain();
		load_config(32'hFFFF_FFC0, 16'd0, 12'd0);
		send(mk_req(REQ_ALLOC, 32'h0000_0000));
		send(mk_req(REQ_FREE, 32'hFFFF_FFC0));

		// oversized count, widest slot, address wrap
		drain();
		load_config(32'hFFFF_FF00, 16'hFFFF, 12'hFFF);
		send(mk_req(REQ_ALLOC, 32'h0000_0000));
		send(mk_req(REQ_FREE, 32'h0000_FEFF));
		send(mk_req(REQ_FREE, 32'hFFFF_FF00));
		send(mk_req(REQ_FREE, 32'hFFFF_FFFF));
		send(mk_req(REQ_ALLOC, 32'h0000_0000));
		send(mk_req(REQ_ALLOC, 32'h0000_0000));

		// last slot of a full-size region, just above and just below
		drain();
		load_config(32'h0000_1000, 16'd16, 12'd2048);
		send(mk_req(REQ_FREE, 32'h0000_8FF0));
		send(mk_req(REQ_FREE, 32'h0000_8FF1));
		send(mk_req(REQ_FREE, 32'h0000_0FFF));

		// shrink the count while a high slot sits on the list
		drain();
		load_config(32'h0000_1000, 16'd0, 12'd1);
		send(mk_req(REQ_ALLOC, 32'h0000_0000));
		send(mk_req(REQ_ALLOC, 32'h0000_0000));
		send(mk_req(REQ_FREE, 32'h0000_1000));

		for (int p = 0; p < PHASES; p++) begin
			drain();
			gap_pct = (p < 4) ? 23 : (p < 8) ? 77 : 0;
			stall_pct = (p < 4) ? 77 : (p < 8) ? 23 : 0;
			case ($urandom_range(5))
				0: nb = 32'd0;
				1: nb = 32'hFFFF_FFFF;
				2: nb = 32'hFFFF_FFFF - $urandom_range(65535);
				default: nb = $urandom;
			endcase
			case ($urandom_range(7))
				0: ns = 16'd0;
				1: ns = 16'd1;
				2: ns = 16'hFFFF;
				3: ns = SIZE_W'($urandom);
				default: ns = SIZE_W'($urandom_range(1, 300));
			endcase
			case ($urandom_range(7))
				0: nc = 12'd0;
				1: nc = 12'd1;
				2: nc = 12'hFFF;
				3: nc = 12'd2048;
				default: nc = CNT_W'($urandom_range(1, 64));
			endcase
			load_config(nb, ns, nc);
			repeat (PHASE_ITEMS) send(random_request());
		end

		drain();
		repeat (40) @(posedge clk);
		if (errors == 0 && outstanding == 0)
			$display("slab_slot_free_list_allocator: match");
		else
			$display("slab_slot_free_list_allocator: mismatch");
		$finish;
	end

endmodule
